// ----- hdl/ddpf_pkg.sv -----
// Package: shared types, register indexes, loop modes and shift constants.
`default_nettype none

package ddpf_pkg;

   localparam int NUM_GAINS  = 8;
   localparam int GAIN_IDX_W = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int WORD_W     = 32;
   localparam int DUTY_W     = 16;
   localparam int MIX_W      = WORD_W + 2;

   localparam int SHIFT_TRANSLATION = 12;
   localparam int SHIFT_ROTATION    = 10;
   localparam int SHIFT_ANGLE_FINE  = 10;

   localparam logic [GAIN_IDX_W-1:0] REG_KP_TRANSLATION = 3'd0;
   localparam logic [GAIN_IDX_W-1:0] REG_KD_TRANSLATION = 3'd1;
   localparam logic [GAIN_IDX_W-1:0] REG_KV_TRANSLATION = 3'd2;
   localparam logic [GAIN_IDX_W-1:0] REG_KA_TRANSLATION = 3'd3;
   localparam logic [GAIN_IDX_W-1:0] REG_KP_ROTATION    = 3'd4;
   localparam logic [GAIN_IDX_W-1:0] REG_KD_ROTATION    = 3'd5;
   localparam logic [GAIN_IDX_W-1:0] REG_KV_ROTATION    = 3'd6;
   localparam logic [GAIN_IDX_W-1:0] REG_KA_ROTATION    = 3'd7;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_BOTH        = 2'd0;
   localparam mode_type MODE_ROTATION    = 2'd1;
   localparam mode_type MODE_TRANSLATION = 2'd2;
   localparam mode_type MODE_NONE        = 2'd3;

   typedef struct packed {
      logic signed [WORD_W-1:0] kp_translation;
      logic signed [WORD_W-1:0] kd_translation;
      logic signed [WORD_W-1:0] kv_translation;
      logic signed [WORD_W-1:0] ka_translation;
      logic signed [WORD_W-1:0] kp_rotation;
      logic signed [WORD_W-1:0] kd_rotation;
      logic signed [WORD_W-1:0] kv_rotation;
      logic signed [WORD_W-1:0] ka_rotation;
   } gains_type;

endpackage

`default_nettype wire

// ----- hdl/ddpf_if.sv -----
// Interfaces: input item channel and result item channel.
`default_nettype none

interface ddpf_req_if;
   import ddpf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] target_distance;
   logic signed [WORD_W-1:0] measured_distance;
   logic signed [WORD_W-1:0] target_angle;
   logic signed [WORD_W-1:0] measured_angle_fine;
   logic signed [WORD_W-1:0] speed_translation;
   logic signed [WORD_W-1:0] accel_translation;
   logic signed [WORD_W-1:0] speed_rotation;
   logic signed [WORD_W-1:0] accel_rotation;
   mode_type                 loop_mode;

   modport source (
      output valid, target_distance, measured_distance, target_angle,
             measured_angle_fine, speed_translation, accel_translation,
             speed_rotation, accel_rotation, loop_mode,
      input  ready
   );

   modport sink (
      input  valid, target_distance, measured_distance, target_angle,
             measured_angle_fine, speed_translation, accel_translation,
             speed_rotation, accel_rotation, loop_mode,
      output ready
   );
endinterface

interface ddpf_rsp_if;
   import ddpf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DUTY_W-1:0] left_drive;
   logic signed [DUTY_W-1:0] right_drive;
   logic                     duty_wrapped;

   modport source (
      output valid, left_drive, right_drive, duty_wrapped,
      input  ready
   );

   modport sink (
      input  valid, left_drive, right_drive, duty_wrapped,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/ddpf_csr.sv -----
// Gain register file behind the APB-style configuration port.
`default_nettype none

module ddpf_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ddpf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ddpf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ddpf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output ddpf_pkg::gains_type                  gains
);
   import ddpf_pkg::*;

   logic [NUM_GAINS-1:0][WORD_W-1:0] gain_ff;
   logic [GAIN_IDX_W-1:0]            index;
   logic                             write_en;

   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = gain_ff[index];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else if (write_en) begin
         gain_ff[index] <= csr_pwdata;
      end
   end

   always_comb begin
      gains.kp_translation = gain_ff[REG_KP_TRANSLATION];
      gains.kd_translation = gain_ff[REG_KD_TRANSLATION];
      gains.kv_translation = gain_ff[REG_KV_TRANSLATION];
      gains.ka_translation = gain_ff[REG_KA_TRANSLATION];
      gains.kp_rotation    = gain_ff[REG_KP_ROTATION];
      gains.kd_rotation    = gain_ff[REG_KD_ROTATION];
      gains.kv_rotation    = gain_ff[REG_KV_ROTATION];
      gains.ka_rotation    = gain_ff[REG_KA_ROTATION];
   end

endmodule

`default_nettype wire

// ----- hdl/differential_drive_pd_feedforward_top.sv -----
// Top level: differential-drive PD controller with velocity/accel feedforward.
//
// req_chan takes one control tick per item: target and measured positions,
// velocity and acceleration set points, and the loop mode. rsp_chan returns
// one item per tick: left and right 16-bit duties and a wrap flag.
// Gains are written through the csr_ port (eight 32-bit registers at 4*i).
//
// Pipeline: input register, error stage, product stage (eight 32x32
// multipliers in parallel), sum stage, duty mix into the result register.
// Throughput is one item per cycle while the receiver does not stall,
// set by the single five-stage pipe. The stored previous errors update
// as each item leaves the input register.
//
// When the receiver stalls with a result waiting, the whole pipe holds and
// req_chan.ready drops; it rises as soon as the result is taken.
// Reset clears gains, previous errors and all stage valid bits.
`default_nettype none

module differential_drive_pd_feedforward_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ddpf_req_if.sink                             req_chan,
   ddpf_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ddpf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ddpf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ddpf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import ddpf_pkg::*;

   gains_type gains;

   ddpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;

   assign advance        = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage 1: input register
   logic signed [WORD_W-1:0] tgt_dist_1_ff, meas_dist_1_ff, tgt_ang_1_ff, meas_ang_1_ff;
   logic signed [WORD_W-1:0] spd_t_1_ff, acc_t_1_ff, spd_r_1_ff, acc_r_1_ff;
   mode_type                 mode_1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         tgt_dist_1_ff  <= req_chan.target_distance;
         meas_dist_1_ff <= req_chan.measured_distance;
         tgt_ang_1_ff   <= req_chan.target_angle;
         meas_ang_1_ff  <= req_chan.measured_angle_fine;
         spd_t_1_ff     <= req_chan.speed_translation;
         acc_t_1_ff     <= req_chan.accel_translation;
         spd_r_1_ff     <= req_chan.speed_rotation;
         acc_r_1_ff     <= req_chan.accel_rotation;
         mode_1_ff      <= req_chan.loop_mode;
      end
   end

   // stage 2: errors and error differences
   logic signed [WORD_W-1:0] last_err_t_ff, last_err_r_ff;
   logic signed [WORD_W-1:0] err_t_in, err_r_in, derr_t_in, derr_r_in;
   logic signed [WORD_W-1:0] err_t_2_ff, err_r_2_ff, derr_t_2_ff, derr_r_2_ff;
   logic signed [WORD_W-1:0] spd_t_2_ff, acc_t_2_ff, spd_r_2_ff, acc_r_2_ff;
   mode_type                 mode_2_ff;

   always_comb begin
      err_t_in  = tgt_dist_1_ff - meas_dist_1_ff;
      err_r_in  = tgt_ang_1_ff - (meas_ang_1_ff >>> SHIFT_ANGLE_FINE);
      derr_t_in = err_t_in - last_err_t_ff;
      derr_r_in = err_r_in - last_err_r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_t_ff <= '0;
         last_err_r_ff <= '0;
      end else if (advance && v1_ff) begin
         last_err_t_ff <= err_t_in;
         last_err_r_ff <= err_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err_t_2_ff  <= err_t_in;
         err_r_2_ff  <= err_r_in;
         derr_t_2_ff <= derr_t_in;
         derr_r_2_ff <= derr_r_in;
         spd_t_2_ff  <= spd_t_1_ff;
         acc_t_2_ff  <= acc_t_1_ff;
         spd_r_2_ff  <= spd_r_1_ff;
         acc_r_2_ff  <= acc_r_1_ff;
         mode_2_ff   <= mode_1_ff;
      end
   end

   // stage 3: products, low 32 bits
   logic signed [WORD_W-1:0] pa_t_3_ff, pv_t_3_ff, pp_t_3_ff, pd_t_3_ff;
   logic signed [WORD_W-1:0] pa_r_3_ff, pv_r_3_ff, pp_r_3_ff, pd_r_3_ff;
   mode_type                 mode_3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_t_3_ff <= acc_t_2_ff * gains.ka_translation;
         pv_t_3_ff <= spd_t_2_ff * gains.kv_translation;
         pp_t_3_ff <= err_t_2_ff * gains.kp_translation;
         pd_t_3_ff <= derr_t_2_ff * gains.kd_translation;
         pa_r_3_ff <= acc_r_2_ff * gains.ka_rotation;
         pv_r_3_ff <= spd_r_2_ff * gains.kv_rotation;
         pp_r_3_ff <= err_r_2_ff * gains.kp_rotation;
         pd_r_3_ff <= derr_r_2_ff * gains.kd_rotation;
         mode_3_ff <= mode_2_ff;
      end
   end

   // stage 4: sums and command scaling
   logic signed [WORD_W-1:0] pv_r_half, sum_t, sum_r, cmd_t_in, cmd_r_in;
   logic signed [WORD_W-1:0] cmd_t_4_ff, cmd_r_4_ff;
   mode_type                 mode_4_ff;

   always_comb begin
      // halve toward zero: bias negatives by one before the shift
      pv_r_half = $signed(pv_r_3_ff + WORD_W'(pv_r_3_ff[WORD_W-1])) >>> 1;
      sum_t     = pa_t_3_ff + pv_t_3_ff + pp_t_3_ff + pd_t_3_ff;
      sum_r     = pa_r_3_ff + pv_r_half + pp_r_3_ff + pd_r_3_ff;
      cmd_t_in  = $signed(-sum_t) >>> SHIFT_TRANSLATION;
      cmd_r_in  = sum_r >>> SHIFT_ROTATION;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_t_4_ff <= cmd_t_in;
         cmd_r_4_ff <= cmd_r_in;
         mode_4_ff  <= mode_3_ff;
      end
   end

   // output stage: duty mix with 16-bit wrap detection
   logic                     trans_on, rot_on, wrap_t, wrap_r, wrap_l;
   logic signed [DUTY_W-1:0] duty_t;
   logic signed [MIX_W-1:0]  cmd_r_wide, right_sum, left_sum;
   logic signed [DUTY_W-1:0] left_drive_in, right_drive_in;
   logic                     duty_wrapped_in;
   logic signed [DUTY_W-1:0] left_drive_ff, right_drive_ff;
   logic                     duty_wrapped_ff;

   always_comb begin
      trans_on   = (mode_4_ff == MODE_BOTH) || (mode_4_ff == MODE_TRANSLATION);
      rot_on     = (mode_4_ff == MODE_BOTH) || (mode_4_ff == MODE_ROTATION);
      duty_t     = trans_on ? cmd_t_4_ff[DUTY_W-1:0] : '0;
      wrap_t     = trans_on && (cmd_t_4_ff != WORD_W'(duty_t));
      cmd_r_wide = MIX_W'(cmd_r_4_ff);
      right_sum  = MIX_W'(duty_t) + cmd_r_wide;
      left_sum   = MIX_W'(duty_t) - cmd_r_wide;
      wrap_r     = rot_on && (right_sum != MIX_W'($signed(right_sum[DUTY_W-1:0])));
      wrap_l     = rot_on && (left_sum != MIX_W'($signed(left_sum[DUTY_W-1:0])));
      right_drive_in  = rot_on ? right_sum[DUTY_W-1:0] : duty_t;
      left_drive_in   = rot_on ? left_sum[DUTY_W-1:0] : duty_t;
      duty_wrapped_in = wrap_t || wrap_r || wrap_l;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_drive_ff   <= left_drive_in;
         right_drive_ff  <= right_drive_in;
         duty_wrapped_ff <= duty_wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         v1_ff    <= req_chan.valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         out_v_ff <= v4_ff;
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.left_drive   = left_drive_ff;
   assign rsp_chan.right_drive  = right_drive_ff;
   assign rsp_chan.duty_wrapped = duty_wrapped_ff;

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> v1_ff)
      else $error("accepted item did not enter the input register");

   a_no_loops_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && v4_ff && (mode_4_ff == MODE_NONE)) |=>
      (rsp_chan.valid && (rsp_chan.left_drive == '0) && (rsp_chan.right_drive == '0)
       && !rsp_chan.duty_wrapped))
      else $error("disabled loops produced nonzero duty");

   a_rotation_mirror: assert property (@(posedge clock) disable iff (reset)
      (advance && v4_ff && (mode_4_ff == MODE_ROTATION)) |=>
      (rsp_chan.left_drive == DUTY_W'(-rsp_chan.right_drive)))
      else $error("rotation-only duties are not mirrored");

endmodule

`default_nettype wire
